@@ src/lseg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lseg_pkg
// Shared types, constants and the colour wheel for the LED strip effect
// generator.
// ----------------------------------------------------------------------------
package lseg_pkg;

	localparam int unsigned NUM_PIXELS_DEF = 16;
	localparam int unsigned INDEX_W        = 6;
	localparam int unsigned RGB_W          = 24;
	localparam int unsigned PADDR_W        = 3;

	localparam logic [2:0]       EFFECT_MODE_RST = 3'd1;
	localparam logic [RGB_W-1:0] SOLID_RGB_RST   = 24'hFF00FF;
	localparam logic [RGB_W-1:0] RGB_WHITE       = 24'hFFFFFF;
	localparam logic [RGB_W-1:0] RGB_BLACK       = 24'h000000;

	localparam logic REG_EFFECT_MODE = 1'b0;
	localparam logic REG_SOLID_RGB   = 1'b1;

	typedef enum logic [2:0] {
		MODE_BLACK         = 3'd0,
		MODE_SOLID         = 3'd1,
		MODE_WHEEL         = 3'd2,
		MODE_STROBE        = 3'd3,
		MODE_CHASE         = 3'd4,
		MODE_CHASE_RAINBOW = 3'd5
	} mode_t;

	function automatic logic [RGB_W-1:0] wheel(input logic [7:0] w);
		logic [7:0] v;
		logic [7:0] u;
		logic [9:0] t3;
		logic [7:0] t;
		logic [RGB_W-1:0] rgb;
		v = 8'd255 - w;
		if (v < 8'd85) begin
			u = v;
		end else if (v < 8'd170) begin
			u = v - 8'd85;
		end else begin
			u = v - 8'd170;
		end
		t3 = {1'b0, u, 1'b0} + {2'b00, u};
		t = t3[7:0];
		if (v < 8'd85) begin
			rgb = {8'd255 - t, 8'd0, t};
		end else if (v < 8'd170) begin
			rgb = {8'd0, t, 8'd255 - t};
		end else begin
			rgb = {t, 8'd255 - t, 8'd0};
		end
		return rgb;
	endfunction

endpackage
`default_nettype wire

@@ src/led_strip_effect_generator_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// led_strip_effect_generator_top
// Turns each frame tick into one colour item per pixel for the selected
// effect, with an APB-style register port for mode and solid colour.
// ----------------------------------------------------------------------------
// After its tick is accepted, the first pixel item of a frame passes through
// the pixel counter stage and then the output register. The pixel counter
// emits one pixel per cycle unless pixel_ready stalls the output; the next
// tick is taken in the cycle the last pixel of the current frame moves to
// the output register. A tick with frame_tick low is taken and emits nothing.
// Reset: effect_mode is solid, solid_rgb is magenta, animation state is zero.
module led_strip_effect_generator_top #(
	parameter int unsigned NUM_PIXELS = lseg_pkg::NUM_PIXELS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [lseg_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,
	input  wire logic                        tick_valid,
	output logic                             tick_ready,
	input  wire logic                        frame_tick,
	output logic                             pixel_valid,
	input  wire logic                        pixel_ready,
	output logic [lseg_pkg::INDEX_W-1:0]     pixel_index,
	output logic [7:0]                       red,
	output logic [7:0]                       green,
	output logic [7:0]                       blue,
	output logic                             frame_last
);

	localparam int unsigned CNT_W = $clog2(NUM_PIXELS);
	localparam logic [CNT_W-1:0] LAST_PIX = CNT_W'(NUM_PIXELS - 1);

	logic [2:0]                  effect_mode_q;
	logic [lseg_pkg::RGB_W-1:0]  solid_rgb_q;
	logic [7:0]                  wheel_offset_q;
	logic [1:0]                  chase_phase_q;
	logic                        strobe_white_q;

	logic                        act_s1;
	logic [CNT_W-1:0]            pix_s1;
	logic [1:0]                  mod3_s1;
	logic [2:0]                  mode_s1;
	logic [lseg_pkg::RGB_W-1:0]  rgb_s1;
	logic [7:0]                  offset_s1;
	logic [1:0]                  phase_s1;
	logic                        strobe_s1;

	logic                        out_valid_q;
	logic [lseg_pkg::INDEX_W-1:0] out_index_q;
	logic [lseg_pkg::RGB_W-1:0]  out_rgb_q;
	logic                        out_last_q;

	logic                        cfg_wr;
	logic                        adv;
	logic                        pix_last;
	logic                        tick_acc;
	logic                        frame_start;
	logic                        lit;
	logic [8:0]                  chase_pos;
	logic [8:0]                  chase_pos_m;
	logic [lseg_pkg::RGB_W-1:0]  pix_rgb;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_comb begin
		unique case (paddr[2])
			lseg_pkg::REG_EFFECT_MODE: prdata = {29'd0, effect_mode_q};
			lseg_pkg::REG_SOLID_RGB:   prdata = {8'd0, solid_rgb_q};
			default:                   prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			effect_mode_q <= lseg_pkg::EFFECT_MODE_RST;
			solid_rgb_q   <= lseg_pkg::SOLID_RGB_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == lseg_pkg::REG_EFFECT_MODE) begin
				effect_mode_q <= pwdata[2:0];
			end else begin
				solid_rgb_q <= pwdata[lseg_pkg::RGB_W-1:0];
			end
		end
	end

	// handshake control
	assign adv         = !out_valid_q || pixel_ready;
	assign pix_last    = (pix_s1 == LAST_PIX);
	assign tick_ready  = !act_s1 || (pix_last && adv);
	assign tick_acc    = tick_valid && tick_ready;
	assign frame_start = tick_acc && frame_tick;

	// animation state, advanced as the frame is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_offset_q <= 8'd0;
			chase_phase_q  <= 2'd0;
			strobe_white_q <= 1'b0;
		end else if (frame_start) begin
			case (effect_mode_q)
				lseg_pkg::MODE_WHEEL:   wheel_offset_q <= wheel_offset_q + 8'd1;
				lseg_pkg::MODE_STROBE:  strobe_white_q <= !strobe_white_q;
				lseg_pkg::MODE_CHASE: begin
					chase_phase_q <= (chase_phase_q >= 2'd2) ? 2'd0 : chase_phase_q + 2'd1;
				end
				lseg_pkg::MODE_CHASE_RAINBOW: begin
					if (chase_phase_q >= 2'd2) begin
						chase_phase_q  <= 2'd0;
						wheel_offset_q <= wheel_offset_q + 8'd1;
					end else begin
						chase_phase_q <= chase_phase_q + 2'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// pixel counter stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
		end else if (tick_acc) begin
			act_s1 <= frame_tick;
		end else if (act_s1 && adv && pix_last) begin
			act_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_start) begin
			pix_s1    <= '0;
			mod3_s1   <= 2'd0;
			mode_s1   <= effect_mode_q;
			rgb_s1    <= solid_rgb_q;
			offset_s1 <= wheel_offset_q;
			phase_s1  <= chase_phase_q;
			strobe_s1 <= strobe_white_q;
		end else if (act_s1 && adv) begin
			pix_s1  <= pix_s1 + CNT_W'(1);
			mod3_s1 <= (mod3_s1 == 2'd2) ? 2'd0 : mod3_s1 + 2'd1;
		end
	end

	// pixel colour
	assign lit         = (mod3_s1 == phase_s1);
	assign chase_pos   = 9'(pix_s1) + {1'b0, offset_s1} - {7'd0, phase_s1};
	assign chase_pos_m = (chase_pos >= 9'd255) ? chase_pos - 9'd255 : chase_pos;

	always_comb begin
		case (mode_s1)
			lseg_pkg::MODE_SOLID:   pix_rgb = rgb_s1;
			lseg_pkg::MODE_WHEEL:   pix_rgb = lseg_pkg::wheel(8'(pix_s1) + offset_s1);
			lseg_pkg::MODE_STROBE: begin
				pix_rgb = strobe_s1 ? lseg_pkg::RGB_WHITE : lseg_pkg::RGB_BLACK;
			end
			lseg_pkg::MODE_CHASE:   pix_rgb = lit ? rgb_s1 : lseg_pkg::RGB_BLACK;
			lseg_pkg::MODE_CHASE_RAINBOW: begin
				pix_rgb = lit ? lseg_pkg::wheel(chase_pos_m[7:0]) : lseg_pkg::RGB_BLACK;
			end
			default:                pix_rgb = lseg_pkg::RGB_BLACK;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= act_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && act_s1) begin
			out_index_q <= lseg_pkg::INDEX_W'(pix_s1);
			out_rgb_q   <= pix_rgb;
			out_last_q  <= pix_last;
		end
	end

	assign pixel_valid = out_valid_q;
	assign pixel_index = out_index_q;
	assign red         = out_rgb_q[23:16];
	assign green       = out_rgb_q[15:8];
	assign blue        = out_rgb_q[7:0];
	assign frame_last  = out_last_q;

endmodule
`default_nettype wire
